// ===== src/ezr_pkg.sv =====
package ezr_pkg;

  // field and datapath widths
  localparam int ANGLE_BITS     = 16;
  localparam int ELEM_FRAC_BITS = 14;
  localparam int ELEM_W         = ELEM_FRAC_BITS + 2;
  localparam int WORK_FRAC      = 30;
  localparam int CORDIC_ITERS   = 30;
  localparam int CW             = 32;
  localparam int PHASE_W        = 32;
  localparam int NUM_LANES      = 3;

  // cordic start vector, gain 0.60725 in q30
  localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

  // one input transaction
  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_r0c0;
    logic signed [ELEM_W-1:0] elem_r1c0;
    logic signed [ELEM_W-1:0] elem_r2c0;
    logic signed [ELEM_W-1:0] elem_r0c1;
    logic signed [ELEM_W-1:0] elem_r1c1;
    logic signed [ELEM_W-1:0] elem_r2c1;
    logic signed [ELEM_W-1:0] elem_r0c2;
    logic signed [ELEM_W-1:0] elem_r1c2;
    logic signed [ELEM_W-1:0] elem_r2c2;
  } out_item_t;

  // rotation state of one angle
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } crd_lane_t;

  // what one cell hands to the next
  typedef struct packed {
    logic                        vld;
    logic [NUM_LANES-1:0][1:0]   quad;
    crd_lane_t [NUM_LANES-1:0]   lane;
  } crd_stage_t;

  // atan(2^-i) in phase units, full turn = 2^32
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    case (i)
      0:       return 32'sd536870912;
      1:       return 32'sd316933406;
      2:       return 32'sd167458907;
      3:       return 32'sd85004756;
      4:       return 32'sd42667331;
      5:       return 32'sd21354465;
      6:       return 32'sd10679838;
      7:       return 32'sd5340245;
      8:       return 32'sd2670163;
      9:       return 32'sd1335087;
      10:      return 32'sd667544;
      11:      return 32'sd333772;
      12:      return 32'sd166886;
      13:      return 32'sd83443;
      14:      return 32'sd41722;
      15:      return 32'sd20861;
      16:      return 32'sd10430;
      17:      return 32'sd5215;
      18:      return 32'sd2608;
      19:      return 32'sd1304;
      20:      return 32'sd652;
      21:      return 32'sd326;
      22:      return 32'sd163;
      23:      return 32'sd81;
      24:      return 32'sd41;
      25:      return 32'sd20;
      26:      return 32'sd10;
      27:      return 32'sd5;
      28:      return 32'sd3;
      29:      return 32'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== src/ezr_cell.sv =====
module ezr_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ezr_pkg::crd_stage_t stage_i,
  output ezr_pkg::crd_stage_t stage_o
);

  localparam logic signed [ezr_pkg::CW-1:0] ATAN = ezr_pkg::atan_q30(IDX);

  ezr_pkg::crd_stage_t stage_nxt;
  ezr_pkg::crd_stage_t stage_r;

  // one micro-rotation on each of the three angles, direction from sign of z
  always_comb begin
    stage_nxt = stage_i;
    for (int l = 0; l < ezr_pkg::NUM_LANES; l++) begin
      if (!stage_i.lane[l].z[ezr_pkg::CW-1]) begin
        stage_nxt.lane[l].x = stage_i.lane[l].x - (stage_i.lane[l].y >>> IDX);
        stage_nxt.lane[l].y = stage_i.lane[l].y + (stage_i.lane[l].x >>> IDX);
        stage_nxt.lane[l].z = stage_i.lane[l].z - ATAN;
      end else begin
        stage_nxt.lane[l].x = stage_i.lane[l].x + (stage_i.lane[l].y >>> IDX);
        stage_nxt.lane[l].y = stage_i.lane[l].y - (stage_i.lane[l].x >>> IDX);
        stage_nxt.lane[l].z = stage_i.lane[l].z + ATAN;
      end
    end
  end

  // stage register, only the valid bit is cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld  <= 1'b0;
      stage_r.quad <= stage_nxt.quad;
      stage_r.lane <= stage_nxt.lane;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// ===== src/ezr_matrix.sv =====
module ezr_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  ezr_pkg::crd_stage_t stage_i,
  output logic                out_valid,
  output ezr_pkg::out_item_t  out_data
);

  localparam int CW  = ezr_pkg::CW;
  localparam int SH  = ezr_pkg::WORK_FRAC - ezr_pkg::ELEM_FRAC_BITS;
  localparam int VW  = CW + 2;
  localparam logic signed [VW-1:0] RND = (SH > 0) ? (VW'(1) <<< (SH - 1)) : '0;
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< ezr_pkg::ELEM_FRAC_BITS;
  localparam logic signed [2*CW-1:0] MRND = (2*CW)'(1) <<< (ezr_pkg::WORK_FRAC - 1);

  // q30 product rounded back to q30
  function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    p = (p + MRND) >>> ezr_pkg::WORK_FRAC;
    return p[CW-1:0];
  endfunction

  // round half up to the element format and clamp to +-1.0
  function automatic logic signed [ezr_pkg::ELEM_W-1:0] to_elem(
      input logic signed [CW:0] v);
    logic signed [VW-1:0] w;
    w = VW'(v);
    w = (w + RND) >>> SH;
    if (w > ONE) begin
      w = ONE;
    end
    if (w < -ONE) begin
      w = -ONE;
    end
    return w[ezr_pkg::ELEM_W-1:0];
  endfunction

  // quadrant map: x = 0, y = 1, z = 2
  logic                 vld_a_r;
  logic signed [CW-1:0] sn_r [3];
  logic signed [CW-1:0] cs_r [3];

  always_ff @(posedge clk) begin
    for (int l = 0; l < ezr_pkg::NUM_LANES; l++) begin
      case (stage_i.quad[l])
        2'd0: begin
          sn_r[l] <= stage_i.lane[l].y;
          cs_r[l] <= stage_i.lane[l].x;
        end
        2'd1: begin
          sn_r[l] <= stage_i.lane[l].x;
          cs_r[l] <= -stage_i.lane[l].y;
        end
        2'd2: begin
          sn_r[l] <= -stage_i.lane[l].y;
          cs_r[l] <= -stage_i.lane[l].x;
        end
        default: begin
          sn_r[l] <= -stage_i.lane[l].x;
          cs_r[l] <= stage_i.lane[l].y;
        end
      endcase
    end
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= stage_i.vld;
    end
  end

  // two-factor products
  logic                 vld_b_r;
  logic signed [CW-1:0] sxsy_r, cxsy_r, cycz_r, szcx_r, sxsz_r, cysz_r;
  logic signed [CW-1:0] cxcz_r, sxcz_r, sxcy_r, cxcy_r, sy_b_r, sz_b_r, cz_b_r;

  always_ff @(posedge clk) begin
    sxsy_r <= mulq(sn_r[0], sn_r[1]);
    cxsy_r <= mulq(cs_r[0], sn_r[1]);
    cycz_r <= mulq(cs_r[1], cs_r[2]);
    szcx_r <= mulq(sn_r[2], cs_r[0]);
    sxsz_r <= mulq(sn_r[0], sn_r[2]);
    cysz_r <= mulq(cs_r[1], sn_r[2]);
    cxcz_r <= mulq(cs_r[0], cs_r[2]);
    sxcz_r <= mulq(sn_r[0], cs_r[2]);
    sxcy_r <= mulq(sn_r[0], cs_r[1]);
    cxcy_r <= mulq(cs_r[0], cs_r[1]);
    sy_b_r <= sn_r[1];
    sz_b_r <= sn_r[2];
    cz_b_r <= cs_r[2];
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  // three-factor products, the rest carried along
  logic                 vld_c_r;
  logic signed [CW-1:0] sxsycz_r, sxsysz_r, cxsycz_r, cxsysz_r;
  logic signed [CW-1:0] cycz_c_r, szcx_c_r, sxsz_c_r, cysz_c_r;
  logic signed [CW-1:0] cxcz_c_r, sxcz_c_r, sxcy_c_r, cxcy_c_r, sy_c_r;

  always_ff @(posedge clk) begin
    sxsycz_r <= mulq(sxsy_r, cz_b_r);
    sxsysz_r <= mulq(sxsy_r, sz_b_r);
    cxsycz_r <= mulq(cxsy_r, cz_b_r);
    cxsysz_r <= mulq(cxsy_r, sz_b_r);
    cycz_c_r <= cycz_r;
    szcx_c_r <= szcx_r;
    sxsz_c_r <= sxsz_r;
    cysz_c_r <= cysz_r;
    cxcz_c_r <= cxcz_r;
    sxcz_c_r <= sxcz_r;
    sxcy_c_r <= sxcy_r;
    cxcy_c_r <= cxcy_r;
    sy_c_r   <= sy_b_r;
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else begin
      vld_c_r <= vld_b_r;
    end
  end

  // element sums, one bit of headroom
  logic signed [CW:0] sum_r1c0, sum_r2c0, sum_r0c1, sum_r1c1, sum_r2c1, sum_r1c2;

  always_comb begin
    sum_r1c0 = (CW+1)'(sxsycz_r) + (CW+1)'(szcx_c_r);
    sum_r2c0 = (CW+1)'(sxsz_c_r) - (CW+1)'(cxsycz_r);
    sum_r0c1 = -(CW+1)'(cysz_c_r);
    sum_r1c1 = (CW+1)'(cxcz_c_r) - (CW+1)'(sxsysz_r);
    sum_r2c1 = (CW+1)'(cxsysz_r) + (CW+1)'(sxcz_c_r);
    sum_r1c2 = -(CW+1)'(sxcy_c_r);
  end

  // output register
  logic                valid_r;
  ezr_pkg::out_item_t  data_r;

  always_ff @(posedge clk) begin
    data_r.elem_r0c0 <= to_elem((CW+1)'(cycz_c_r));
    data_r.elem_r1c0 <= to_elem(sum_r1c0);
    data_r.elem_r2c0 <= to_elem(sum_r2c0);
    data_r.elem_r0c1 <= to_elem(sum_r0c1);
    data_r.elem_r1c1 <= to_elem(sum_r1c1);
    data_r.elem_r2c1 <= to_elem(sum_r2c1);
    data_r.elem_r0c2 <= to_elem((CW+1)'(sy_c_r));
    data_r.elem_r1c2 <= to_elem(sum_r1c2);
    data_r.elem_r2c2 <= to_elem((CW+1)'(cxcy_c_r));
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld_c_r;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/euler_to_rotation_matrix.sv =====
// pipeline: an accepted start passes through 30 cordic cells, the quadrant map,
//   two multiply stages and a sum and round stage before the result strobe
// throughput: one angle triple per cycle, busy never rises, set by the cell chain
// reset: synchronous active-low rst_n clears every valid bit, flushing all
//   transactions in flight; the result side cannot stall, so nothing backs up
module euler_to_rotation_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ezr_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ezr_pkg::out_item_t out_data
);

  localparam int NI  = ezr_pkg::CORDIC_ITERS;
  localparam int LAT = NI + 4;
  localparam int AB  = ezr_pkg::ANGLE_BITS;
  localparam int PW  = ezr_pkg::PHASE_W;

  logic in_acc;
  logic [PW-1:0] phase [3];
  ezr_pkg::crd_stage_t chain [NI+1];

  // pipeline never stalls
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // angle to 32-bit phase, quadrant from the top two bits
  assign phase[0] = {in_data.angle_x, (PW-AB)'(0)};
  assign phase[1] = {in_data.angle_y, (PW-AB)'(0)};
  assign phase[2] = {in_data.angle_z, (PW-AB)'(0)};

  always_comb begin
    chain[0].vld = in_acc;
    for (int l = 0; l < ezr_pkg::NUM_LANES; l++) begin
      chain[0].quad[l]   = phase[l][PW-1 -: 2];
      chain[0].lane[l].x = ezr_pkg::CORDIC_GAIN;
      chain[0].lane[l].y = '0;
      chain[0].lane[l].z = ezr_pkg::CW'(phase[l][PW-3:0]);
    end
  end

  // cordic cell chain
  for (genvar i = 0; i < NI; i++) begin : g_cell
    ezr_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // products, sums and output register
  ezr_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_i   (chain[NI]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // every accepted transaction gives a strobe after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LAT out_valid)
    else $error("result strobe missing after accepted transaction");

  // no strobe without a transaction accepted the fixed latency earlier
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result strobe without matching transaction");

  // diagonal elements r0c0 and r1c1 stay within plus or minus one
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.elem_r0c0 <= (ezr_pkg::ELEM_W)'(1 << ezr_pkg::ELEM_FRAC_BITS)) &&
                  (out_data.elem_r0c0 >= -(ezr_pkg::ELEM_W)'(1 << ezr_pkg::ELEM_FRAC_BITS)) &&
                  (out_data.elem_r1c1 <= (ezr_pkg::ELEM_W)'(1 << ezr_pkg::ELEM_FRAC_BITS)) &&
                  (out_data.elem_r1c1 >= -(ezr_pkg::ELEM_W)'(1 << ezr_pkg::ELEM_FRAC_BITS)))
    else $error("matrix element outside saturation range");

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // element vector view of one result, index 8 is r0c0 and index 0 is r2c2
  typedef logic [8:0][ezr_pkg::ELEM_W-1:0] elem_vec_t;

  // atan(2^-i) in phase units, full turn = 2^32
  localparam longint ATAN_STEP [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };
  localparam longint START_GAIN  = 652032874;
  localparam longint HALF_LSB_30 = 64'sd536870912;
  localparam int     ROUND_SHIFT = 30 - ezr_pkg::ELEM_FRAC_BITS;
  localparam int     LATENCY     = 34;

  // expected rotation matrices and their comparison
  class matrix_scoreboard;
    ezr_pkg::out_item_t matrices_due [$];
    int                 mismatches;
    string              elem_name [0:8];

    function new();
      mismatches = 0;
      elem_name = '{"r2c2", "r1c2", "r0c2", "r2c1", "r1c1", "r0c1",
                    "r2c0", "r1c0", "r0c0"};
    endfunction

    // cordic sine and cosine of one binary angle, q30
    function void sin_cos(input logic [ezr_pkg::ANGLE_BITS-1:0] ang, output longint s,
                          output longint c);
      logic [31:0] phase;
      longint      x, y, z, dx, dy;
      int          i;
      phase = {ang, {(32-ezr_pkg::ANGLE_BITS){1'b0}}};
      z = longint'({34'd0, phase[29:0]});
      x = START_GAIN;
      y = 0;
      for (i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_STEP[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_STEP[i];
        end
      end
      // fold back into the quadrant
      case (phase[31:30])
        2'd0: begin s = y;  c = x;  end
        2'd1: begin s = x;  c = -y; end
        2'd2: begin s = -y; c = -x; end
        default: begin s = -x; c = y; end
      endcase
    endfunction

    function longint mul_q30(longint a, longint b);
      return (a * b + HALF_LSB_30) >>> 30;
    endfunction

    // round half up to the element format and clamp to one
    function logic [ezr_pkg::ELEM_W-1:0] to_elem(longint v);
      longint r;
      longint one;
      one = longint'(1) << ezr_pkg::ELEM_FRAC_BITS;
      r = (v + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[ezr_pkg::ELEM_W-1:0];
    endfunction

    function ezr_pkg::out_item_t rotation_of(ezr_pkg::in_item_t a);
      longint             sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      ezr_pkg::out_item_t m;
      sin_cos(a.angle_x, sx, cx);
      sin_cos(a.angle_y, sy, cy);
      sin_cos(a.angle_z, sz, cz);
      sxsy = mul_q30(sx, sy);
      cxsy = mul_q30(cx, sy);
      m.elem_r0c0 = to_elem(mul_q30(cy, cz));
      m.elem_r1c0 = to_elem(mul_q30(sxsy, cz) + mul_q30(sz, cx));
      m.elem_r2c0 = to_elem(mul_q30(sx, sz) - mul_q30(cxsy, cz));
      m.elem_r0c1 = to_elem(-mul_q30(cy, sz));
      m.elem_r1c1 = to_elem(mul_q30(cx, cz) - mul_q30(sxsy, sz));
      m.elem_r2c1 = to_elem(mul_q30(cxsy, sz) + mul_q30(sx, cz));
      m.elem_r0c2 = to_elem(sy);
      m.elem_r1c2 = to_elem(-mul_q30(sx, cy));
      m.elem_r2c2 = to_elem(mul_q30(cx, cy));
      return m;
    endfunction

    function void note_angles(ezr_pkg::in_item_t a);
      matrices_due.push_back(rotation_of(a));
    endfunction

    function void check_matrix(ezr_pkg::out_item_t got);
      ezr_pkg::out_item_t want;
      elem_vec_t          e, g;
      int                 k;
      if (matrices_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = matrices_due.pop_front();
      e = want;
      g = got;
      for (k = 8; k >= 0; k--) begin
        if (g[k] !== e[k]) begin
          $display("%0t: elem_%s expected %0d actual %0d", $time, elem_name[k],
                   $signed(e[k]), $signed(g[k]));
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return matrices_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  ezr_pkg::in_item_t  in_data;
  logic               out_valid;
  ezr_pkg::out_item_t out_data;

  matrix_scoreboard sb = new();

  euler_to_rotation_matrix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both sides of the block
  always @(posedge clk) begin
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) sb.note_angles(in_data);
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_matrix(out_data);
  end

  function automatic logic [15:0] rand16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic ezr_pkg::in_item_t angles(logic [15:0] ax, logic [15:0] ay,
                                               logic [15:0] az);
    ezr_pkg::in_item_t a;
    a.angle_x = ax;
    a.angle_y = ay;
    a.angle_z = az;
    return a;
  endfunction

  // uniform angles mixed with ones near quadrant and octant boundaries
  function automatic logic [15:0] pick_angle();
    logic [15:0] special [0:7];
    logic [15:0] base;
    logic [15:0] off;
    special = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h4000,
                16'hc000, 16'h2000};
    case ($urandom_range(0, 3))
      0, 1: return rand16();
      2: begin
        base = 16'($urandom_range(0, 7)) << 13;
        off = 16'($urandom_range(0, 6));
        return base + off - 16'd3;
      end
      default: return special[$urandom_range(0, 7)];
    endcase
  endfunction

  // present one transaction and hold it until accepted
  task automatic send_angles(ezr_pkg::in_item_t a);
    start <= 1'b1;
    in_data <= a;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // sender idles with junk on the data lines
  task automatic idle_for(int n);
    start <= 1'b0;
    in_data <= angles(rand16(), rand16(), rand16());
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    wait_drained();
  endtask

  // stimulus
  initial begin
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, half turn, largest field, quarter and eighth turns
    send_angles(angles(16'h0000, 16'h0000, 16'h0000));
    send_angles(angles(16'h8000, 16'h8000, 16'h8000));
    send_angles(angles(16'h7fff, 16'h7fff, 16'h7fff));
    send_angles(angles(16'h8000, 16'h0000, 16'h0000));
    send_angles(angles(16'h0000, 16'h8000, 16'h0000));
    send_angles(angles(16'h0000, 16'h0000, 16'h8000));
    send_angles(angles(16'h7fff, 16'h0000, 16'h0000));
    send_angles(angles(16'h0000, 16'h7fff, 16'h0000));
    send_angles(angles(16'h0000, 16'h0000, 16'h7fff));
    send_angles(angles(16'h4000, 16'h0000, 16'h0000));
    send_angles(angles(16'h0000, 16'h4000, 16'h0000));
    send_angles(angles(16'h0000, 16'h0000, 16'h4000));
    send_angles(angles(16'hc000, 16'h0000, 16'h0000));
    send_angles(angles(16'h0000, 16'hc000, 16'h0000));
    send_angles(angles(16'h0000, 16'h0000, 16'hc000));
    send_angles(angles(16'h4000, 16'h4000, 16'h4000));
    send_angles(angles(16'hc000, 16'h4000, 16'hc000));
    send_angles(angles(16'h2000, 16'h2000, 16'h2000));
    send_angles(angles(16'h0001, 16'hffff, 16'h0001));
    send_angles(angles(16'hffff, 16'h0001, 16'hffff));
    send_angles(angles(16'h5555, 16'haaaa, 16'h1234));
    send_angles(angles(16'haaaa, 16'h5555, 16'hedcb));
    hold_until_drained();

    // random: bursts of idling early, back to back at the end
    for (n = 0; n < 1000; n++) begin
      send_angles(angles(pick_angle(), pick_angle(), pick_angle()));
      if (n == 400) hold_until_drained();
      else if (n < 800 && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 17));
    end

    hold_until_drained();
    repeat (LATENCY + 6) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
